// ===== hdl/pfc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, codes and helpers for the 5x5 digraph cipher block.
// ----------------------------------------------------------------------------
package pfc_pkg;

  // sizes of the square and the alphabet
  localparam int SIDE         = 5;
  localparam int CELL_COUNT   = SIDE * SIDE;
  localparam int LETTER_COUNT = 26;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] coord_t;

  localparam letter_t LETTER_I    = 5'd8;
  localparam letter_t LETTER_J    = 5'd9;
  localparam letter_t LETTER_LAST = 5'd25;
  localparam letter_t PAD_RESET   = 5'd23;
  localparam cell_t   CELLS       = 5'd25;
  localparam coord_t  COORD_LAST  = 3'd4;

  // opcodes
  localparam logic [1:0] OP_KEY    = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_ENC    = 2'd2;
  localparam logic [1:0] OP_DEC    = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DUP       = 2'd1;
  localparam logic [1:0] ST_LONG      = 2'd2;
  localparam logic [1:0] ST_NOT_READY = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    letter_t    first_letter;
    letter_t    second_letter;
    logic       second_present;
  } in_item_t;

  typedef struct packed {
    letter_t    out_first;
    letter_t    out_second;
    logic [1:0] status;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0] opcode;
    letter_t    a;
    letter_t    b;
  } cmd_t;

  // saturate codes above z, fold j onto i
  function automatic letter_t norm_letter(letter_t v);
    letter_t c;
    c = v;
    if (c > LETTER_LAST) c = LETTER_LAST;
    if (c == LETTER_J) c = LETTER_I;
    return c;
  endfunction

  function automatic coord_t cell_row(cell_t p);
    coord_t r;
    if (p >= 5'd20)      r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  function automatic coord_t cell_col(cell_t p);
    cell_t t;
    coord_t r;
    r = cell_row(p);
    t = p - {r, 2'b00} - {2'b00, r};
    return t[2:0];
  endfunction

  function automatic cell_t cell_at(coord_t r, coord_t c);
    return {r, 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

  // one step along a row or column, wrapping at the edge
  function automatic coord_t wrap_step(coord_t v, logic dec);
    coord_t n;
    if (dec) begin
      n = (v == 3'd0) ? COORD_LAST : v - 3'd1;
    end else begin
      n = (v == COORD_LAST) ? 3'd0 : v + 3'd1;
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/pfc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hdl/pfc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_front
// Accepts input beats, normalizes letters, applies the pad letter and queues
// classified commands for the back end. Holds the pad letter register.
// ----------------------------------------------------------------------------
module pfc_front
  import pfc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  output      logic     full,
  input  wire in_item_t in_item,
  input  wire logic     cfg_valid,
  output      logic     cfg_ready,
  input  wire letter_t  cfg_data,
  output      logic     cmd_valid,
  output      cmd_t     cmd,
  input  wire logic     cmd_pop
);

  letter_t    pad_r;
  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       accept;
  cmd_t       new_cmd;

  assign cfg_ready = 1'b1;
  assign full      = (cnt_r == 2'd2);
  assign accept    = push && !full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  // classify the incoming beat
  always_comb begin
    new_cmd.opcode = in_item.opcode;
    new_cmd.a      = norm_letter(in_item.first_letter);
    new_cmd.b      = in_item.second_present ? norm_letter(in_item.second_letter)
                                            : norm_letter(pad_r);
  end

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && !cmd_pop)      cnt_nxt = cnt_r + 2'd1;
    else if (!accept && cmd_pop) cnt_nxt = cnt_r - 2'd1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_r    <= PAD_RESET;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) pad_r <= cfg_data;
      if (accept) wr_ptr_r <= !wr_ptr_r;
      if (cmd_pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pfc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_back
// Executes commands: builds the square from key letters, fills the rest on
// finish, and looks up enciphered or deciphered pairs through the RAMs.
// ----------------------------------------------------------------------------
module pfc_back
  import pfc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cmd_valid,
  input  wire cmd_t      cmd,
  output      logic      cmd_pop,
  input  wire logic      res_full,
  output      logic      res_push,
  output      out_item_t res_item
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FILL = 2'd1;
  localparam logic [1:0] S_POS  = 2'd2;
  localparam logic [1:0] S_SQ   = 2'd3;

  logic [1:0]              state_r, state_nxt;
  cell_t                   key_len_r, key_len_nxt;
  logic                    ready_r, ready_nxt;
  logic [LETTER_COUNT-1:0] present_r, present_nxt;
  letter_t                 c_r, c_nxt;
  cell_t                   cell_r, cell_nxt;
  logic                    dec_r, dec_nxt;

  logic    we;
  letter_t wr_letter;
  cell_t   wr_cell;
  logic    pos_re;
  logic    sq_re;
  cell_t   pos_rdata0, pos_rdata1;
  letter_t sq_rdata0, sq_rdata1;
  cell_t   n1, n2;
  cell_t   p1, p2;
  coord_t  r1, c1, r2, c2;

  // letter to cell, two copies for two read ports
  pfc_ram #(.WIDTH(5), .DEPTH(LETTER_COUNT)) u_pos0 (
    .clk(clk), .we(we), .waddr(wr_letter), .wdata(wr_cell),
    .re(pos_re), .raddr(cmd.a), .rdata(pos_rdata0)
  );
  pfc_ram #(.WIDTH(5), .DEPTH(LETTER_COUNT)) u_pos1 (
    .clk(clk), .we(we), .waddr(wr_letter), .wdata(wr_cell),
    .re(pos_re), .raddr(cmd.b), .rdata(pos_rdata1)
  );

  // cell to letter, two copies for two read ports
  pfc_ram #(.WIDTH(5), .DEPTH(CELL_COUNT)) u_sq0 (
    .clk(clk), .we(we), .waddr(wr_cell), .wdata(wr_letter),
    .re(sq_re), .raddr(n1), .rdata(sq_rdata0)
  );
  pfc_ram #(.WIDTH(5), .DEPTH(CELL_COUNT)) u_sq1 (
    .clk(clk), .we(we), .waddr(wr_cell), .wdata(wr_letter),
    .re(sq_re), .raddr(n2), .rdata(sq_rdata1)
  );

  // pair rule on the looked-up positions
  always_comb begin
    p1 = (pos_rdata0 >= CELLS) ? 5'd0 : pos_rdata0;
    p2 = (pos_rdata1 >= CELLS) ? 5'd0 : pos_rdata1;
    r1 = cell_row(p1);
    c1 = cell_col(p1);
    r2 = cell_row(p2);
    c2 = cell_col(p2);
    if (r1 == r2) begin
      n1 = cell_at(r1, wrap_step(c1, dec_r));
      n2 = cell_at(r2, wrap_step(c2, dec_r));
    end else if (c1 == c2) begin
      n1 = cell_at(wrap_step(r1, dec_r), c1);
      n2 = cell_at(wrap_step(r2, dec_r), c2);
    end else begin
      n1 = cell_at(r1, c2);
      n2 = cell_at(r2, c1);
    end
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    key_len_nxt = key_len_r;
    ready_nxt   = ready_r;
    present_nxt = present_r;
    c_nxt       = c_r;
    cell_nxt    = cell_r;
    dec_nxt     = dec_r;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    res_item    = '0;
    we          = 1'b0;
    wr_letter   = '0;
    wr_cell     = '0;
    pos_re      = 1'b0;
    sq_re       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid && !res_full) begin
          cmd_pop = 1'b1;
          case (cmd.opcode)
            OP_KEY: begin
              res_push = 1'b1;
              if (key_len_r >= CELLS) begin
                res_item.status = ST_LONG;
              end else if (present_r[cmd.a]) begin
                res_item.status = ST_DUP;
              end else begin
                we                 = 1'b1;
                wr_letter          = cmd.a;
                wr_cell            = key_len_r;
                present_nxt[cmd.a] = 1'b1;
                key_len_nxt        = key_len_r + 5'd1;
                res_item.status    = ST_OK;
              end
            end
            OP_FINISH: begin
              if (ready_r) begin
                res_push        = 1'b1;
                res_item.status = ST_OK;
              end else begin
                state_nxt = S_FILL;
                c_nxt     = '0;
                cell_nxt  = key_len_r;
              end
            end
            default: begin
              if (!ready_r) begin
                res_push        = 1'b1;
                res_item.status = ST_NOT_READY;
              end else begin
                pos_re    = 1'b1;
                dec_nxt   = (cmd.opcode == OP_DEC);
                state_nxt = S_POS;
              end
            end
          endcase
        end
      end
      S_FILL: begin
        // one alphabet letter per cycle, unused ones go to the next cell
        if (c_r != LETTER_J && !present_r[c_r] && cell_r < CELLS) begin
          we               = 1'b1;
          wr_letter        = c_r;
          wr_cell          = cell_r;
          present_nxt[c_r] = 1'b1;
          cell_nxt         = cell_r + 5'd1;
        end
        if (c_r == LETTER_LAST) begin
          ready_nxt       = 1'b1;
          res_push        = 1'b1;
          res_item.status = ST_OK;
          state_nxt       = S_IDLE;
        end else begin
          c_nxt = c_r + 5'd1;
        end
      end
      S_POS: begin
        sq_re     = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        res_push          = 1'b1;
        res_item.out_first  = sq_rdata0;
        res_item.out_second = sq_rdata1;
        res_item.status     = ST_OK;
        state_nxt           = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      key_len_r <= '0;
      ready_r   <= 1'b0;
      present_r <= '0;
    end else begin
      state_r   <= state_nxt;
      key_len_r <= key_len_nxt;
      ready_r   <= ready_nxt;
      present_r <= present_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    c_r    <= c_nxt;
    cell_r <= cell_nxt;
    dec_r  <= dec_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/pfc_result_q.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_result_q
// Two-entry result queue between the back end and the output port.
// ----------------------------------------------------------------------------
module pfc_result_q
  import pfc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      res_push,
  input  wire out_item_t res_item,
  output      logic      res_full,
  output      logic      empty,
  input  wire logic      pop,
  output      out_item_t out_item
);

  out_item_t  q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       take;

  assign res_full = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign take     = pop && !empty;
  assign out_item = q_r[rd_ptr_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (res_push && !take)      cnt_nxt = cnt_r + 2'd1;
    else if (!res_push && take) cnt_nxt = cnt_r - 2'd1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (res_push) wr_ptr_r <= !wr_ptr_r;
      if (take) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (res_push) begin
      q_r[wr_ptr_r] <= res_item;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/playfair_digraph_cipher.sv =====
// Throughput: key items 1 per cycle while the result queue has room. A pair holds
//   the back end through the position RAM read and the dependent square RAM read,
//   and the first finish holds it while the fill walks the alphabet.
// Reset: synchronous, active low; clears queues, key length and letter marks,
//   pad letter returns to x. No clearing pass is needed.
`default_nettype none
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// 5x5 digraph cipher: key entry, square completion, pair encipher/decipher.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher
  import pfc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  output      logic      full,
  input  wire in_item_t  in_item,
  output      logic      empty,
  input  wire logic      pop,
  output      out_item_t out_item,
  input  wire logic      cfg_valid,
  output      logic      cfg_ready,
  input  wire letter_t   cfg_data
);

  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_pop;
  logic      res_full;
  logic      res_push;
  out_item_t res_item;

  // intake and classification
  pfc_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  // execution
  pfc_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_pop(cmd_pop), .res_full(res_full), .res_push(res_push),
    .res_item(res_item)
  );

  // result buffering
  pfc_result_q u_result_q (
    .clk(clk), .rst_n(rst_n), .res_push(res_push), .res_item(res_item),
    .res_full(res_full), .empty(empty), .pop(pop), .out_item(out_item)
  );

`ifndef NO_ASSERTIONS
  // back end never writes a result into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  // back end only takes a command that is there
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  // an accepted beat is waiting for the back end in the next cycle
  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full) |=> cmd_valid)
    else $error("accepted beat not queued");

  // rejected pairs carry zero letters
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.status == ST_NOT_READY) |->
      (out_item.out_first == 5'd0 && out_item.out_second == 5'd0))
    else $error("rejected pair has nonzero letters");
`endif

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 5x5 digraph cipher. Builds one square from
// key beats, finishes it, then runs directed pair rules and random traffic
// while a predictor in the bench tracks the square, the key letters and the
// pad letter and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pfc_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int END_WAIT     = 40;
  localparam int CHUNK_ITEMS  = 380;
  localparam int CHUNK_COUNT  = 5;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      push      = 1'b0;
  logic      full;
  in_item_t  in_item   = '0;
  logic      empty;
  logic      pop       = 1'b0;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  letter_t   cfg_data  = PAD_RESET;

  // square state as the bench sees it
  letter_t   sq_cell [CELL_COUNT]       = '{default: '0};
  bit        letter_held [LETTER_COUNT] = '{default: 1'b0};
  int        letter_cell [LETTER_COUNT] = '{default: 0};
  int        held_keys   = 0;
  bit        square_done = 1'b0;
  letter_t   pad_value   = PAD_RESET;

  out_item_t cipher_due[$];
  int        errors      = 0;
  int        quiet       = 0;
  bit        jitter_on   = 1'b1;
  int        pop_stall   = 0;

  // key letters already sent, tracked on the sending side
  bit        sent_key [LETTER_COUNT] = '{default: 1'b0};
  int        sent_keys = 0;

  playfair_digraph_cipher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // codes past z become z, j becomes i
  function automatic letter_t fold_letter(letter_t code);
    letter_t l;
    l = (int'(code) >= LETTER_COUNT) ? LETTER_LAST : code;
    if (l == LETTER_J) l = LETTER_I;
    return l;
  endfunction

  function automatic void set_cell(letter_t l, int c);
    sq_cell[c]     = l;
    letter_held[l] = 1'b1;
    letter_cell[l] = c;
  endfunction

  // next state and result for one accepted input beat
  function automatic out_item_t cipher_predict(in_item_t it);
    out_item_t res;
    letter_t   a, b;
    int        fill_at, step, p1, p2, r1, c1, r2, c2, n1, n2;
    res = '0;
    a = fold_letter(it.first_letter);
    b = it.second_present ? fold_letter(it.second_letter) : fold_letter(pad_value);
    case (it.opcode)
      OP_KEY: begin
        if (held_keys >= CELL_COUNT) begin
          res.status = ST_LONG;
        end else if (letter_held[a]) begin
          res.status = ST_DUP;
        end else begin
          set_cell(a, held_keys);
          held_keys++;
        end
      end
      OP_FINISH: begin
        // unused letters go into the free cells in alphabet order
        if (!square_done) begin
          fill_at = held_keys;
          for (int c = 0; c < LETTER_COUNT; c++) begin
            if (c != int'(LETTER_J) && !letter_held[c] && fill_at < CELL_COUNT) begin
              set_cell(letter_t'(c), fill_at);
              fill_at++;
            end
          end
          square_done = 1'b1;
        end
      end
      default: begin
        if (!square_done) begin
          res.status = ST_NOT_READY;
        end else begin
          step = (it.opcode == OP_ENC) ? 1 : SIDE - 1;
          p1 = letter_cell[a];
          p2 = letter_cell[b];
          r1 = p1 / SIDE;
          c1 = p1 % SIDE;
          r2 = p2 / SIDE;
          c2 = p2 % SIDE;
          if (r1 == r2) begin
            n1 = r1 * SIDE + (c1 + step) % SIDE;
            n2 = r2 * SIDE + (c2 + step) % SIDE;
          end else if (c1 == c2) begin
            n1 = ((r1 + step) % SIDE) * SIDE + c1;
            n2 = ((r2 + step) % SIDE) * SIDE + c2;
          end else begin
            n1 = r1 * SIDE + c2;
            n2 = r2 * SIDE + c1;
          end
          res.out_first  = sq_cell[n1];
          res.out_second = sq_cell[n2];
        end
      end
    endcase
    return res;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // track config, input and result beats; watchdog on quiet cycles
  always @(posedge clk) begin
    out_item_t want;
    bit        moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        pad_value = cfg_data;
        moved = 1'b1;
      end
      if (push && !full) begin
        cipher_due.insert(cipher_due.size(), cipher_predict(in_item));
        moved = 1'b1;
      end
      if (pop && !empty) begin
        moved = 1'b1;
        if (cipher_due.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, actual %0d %0d status %0d",
                   $time, out_item.out_first, out_item.out_second, out_item.status);
        end else begin
          want = cipher_due.pop_front();
          check_field("out_first", want.out_first, out_item.out_first);
          check_field("out_second", want.out_second, out_item.out_second);
          check_field("status", want.status, out_item.status);
        end
      end
      quiet = moved ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("playfair_digraph_cipher verification failed");
        $finish;
      end
    end
  end

  // result side: now and then hold pop low for a random stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (pop_stall > 0) begin
      pop_stall--;
      pop <= 1'b0;
    end else if (jitter_on && $urandom_range(0, 11) == 0) begin
      pop_stall = $urandom_range(0, 12);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  function automatic in_item_t mk_item(logic [1:0] op, letter_t f, letter_t s, logic sp);
    in_item_t it;
    it.opcode         = op;
    it.first_letter   = f;
    it.second_letter  = s;
    it.second_present = sp;
    return it;
  endfunction

  // mostly a..z, now and then a code past z
  function automatic letter_t rand_code();
    if ($urandom_range(0, 9) == 0) return letter_t'($urandom_range(26, 31));
    return letter_t'($urandom_range(0, 25));
  endfunction

  function automatic logic [1:0] rand_pair_op();
    return $urandom_range(0, 1) ? OP_DEC : OP_ENC;
  endfunction

  // one input beat, now and then with a random gap ahead of it; push stays high afterwards
  task automatic send_item(in_item_t it);
    int gap;
    if (jitter_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 13);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
  endtask

  task automatic send_key(letter_t code);
    letter_t l;
    l = fold_letter(code);
    if (sent_keys < CELL_COUNT && !sent_key[l]) begin
      sent_key[l] = 1'b1;
      sent_keys++;
    end
    send_item(mk_item(OP_KEY, code, letter_t'($urandom_range(0, 31)),
                      logic'($urandom_range(0, 1))));
  endtask

  // stop sending until every expected result beat is back
  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk); while (cipher_due.size() != 0);
  endtask

  task automatic write_pad(letter_t v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // pairs sent before the square exists are refused
  task automatic test_pairs_before_square();
    send_item(mk_item(OP_ENC, 5'd0, LETTER_LAST, 1'b1));
    send_item(mk_item(OP_DEC, 5'd31, 5'd0, 1'b0));
  endtask

  // key letters: j onto i, saturation, duplicates, then random fill
  task automatic test_key_entry();
    int      goal;
    letter_t l;
    send_key(LETTER_J);
    send_key(LETTER_I);
    send_key(5'd31);
    send_key(5'd26);
    send_key(5'd0);
    goal = ($urandom_range(0, 2) == 0) ? CELL_COUNT : $urandom_range(3, CELL_COUNT - 1);
    while (sent_keys < goal) begin
      if ($urandom_range(0, 1)) begin
        do l = letter_t'($urandom_range(0, 25)); while (l == LETTER_J || sent_key[l]);
        send_key(l);
      end else begin
        send_key(rand_code());
      end
    end
    // a full key refuses any further letter
    if (goal == CELL_COUNT) begin
      send_key(rand_code());
      send_key(LETTER_J);
    end
  endtask

  // finish, finish again, then a key letter on a finished square
  task automatic test_finish_square();
    send_item(mk_item(OP_FINISH, rand_code(), rand_code(), 1'b1));
    send_item(mk_item(OP_FINISH, rand_code(), rand_code(), 1'b0));
    send_item(mk_item(OP_KEY, 5'd1, 5'd0, 1'b1));
    drain_results();
  endtask

  // row, column and rectangle rules with edge wrap, both directions
  task automatic test_pair_rules();
    int first_cell  [6] = '{0, 4, 0, 20, 0, 7};
    int second_cell [6] = '{1, 0, 5, 0, 6, 7};
    for (int i = 0; i < 6; i++) begin
      send_item(mk_item(OP_ENC, sq_cell[first_cell[i]], sq_cell[second_cell[i]], 1'b1));
      send_item(mk_item(OP_DEC, sq_cell[first_cell[i]], sq_cell[second_cell[i]], 1'b1));
    end
    send_item(mk_item(OP_ENC, LETTER_J, LETTER_I, 1'b1));
    send_item(mk_item(OP_DEC, 5'd31, 5'd27, 1'b1));
    // pad letter straight out of reset
    send_item(mk_item(OP_ENC, rand_code(), 5'd31, 1'b0));
    send_item(mk_item(OP_DEC, PAD_RESET, 5'd0, 1'b0));
  endtask

  // pad register at its extremes, j and a code past z
  task automatic test_pad_register();
    letter_t pads [4] = '{5'd0, LETTER_LAST, 5'd31, LETTER_J};
    foreach (pads[k]) begin
      write_pad(pads[k]);
      repeat (3) send_item(mk_item(rand_pair_op(), rand_code(), rand_code(), 1'b0));
    end
  endtask

  // mostly pairs, some key and finish beats as noise; the third and the last chunk run flat out
  task automatic test_random_traffic();
    int r;
    for (int k = 0; k < CHUNK_COUNT; k++) begin
      write_pad(letter_t'($urandom_range(0, 31)));
      jitter_on = (k != 2) && (k != CHUNK_COUNT - 1);
      repeat (CHUNK_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          send_item(mk_item(OP_KEY, rand_code(), letter_t'($urandom_range(0, 31)),
                            logic'($urandom_range(0, 1))));
        end else if (r < 8) begin
          send_item(mk_item(OP_FINISH, rand_code(), letter_t'($urandom_range(0, 31)),
                            logic'($urandom_range(0, 1))));
        end else begin
          send_item(mk_item(rand_pair_op(), rand_code(), rand_code(),
                            logic'($urandom_range(0, 3) != 0)));
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_pairs_before_square();
    test_key_entry();
    test_finish_square();
    test_pair_rules();
    test_pad_register();
    test_random_traffic();
    drain_results();
    repeat (END_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("playfair_digraph_cipher verification clean");
    end else begin
      $display("playfair_digraph_cipher verification failed");
    end
    $finish;
  end

endmodule
